### rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg: shared types and constants of the boot packet deframer
// Status codes, register indexes, frame state and result structures.
// ----------------------------------------------------------------------------
package bpd_pkg;

    // Final status of one receive buffer
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNCATED  = 3'd1,
        ST_BAD_START  = 3'd2,
        ST_ZERO_LEN   = 3'd3,
        ST_DEV_ERROR  = 3'd4,
        ST_BAD_END    = 3'd5,
        ST_CHECKSUM   = 3'd6
    } status_t;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;
    localparam logic [1:0] REG_ERROR_MASK = 2'd2;

    localparam logic [7:0] START_BYTE_RESET = 8'h81;
    localparam logic [7:0] END_BYTE_RESET   = 8'h03;
    localparam logic [7:0] ERROR_MASK_RESET = 8'h80;

    // Shortest buffer that can carry a complete frame
    localparam logic [16:0] MIN_FRAME_BYTES = 17'd6;
    // Frame header bytes before the payload: start, length high/low, response
    localparam logic [16:0] HEADER_BYTES    = 17'd4;

    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] error_mask;
    } cfg_t;

    typedef struct packed {
        logic [16:0] byte_position;
        logic [15:0] frame_length;
        logic [7:0]  response_hold;
        logic [7:0]  running_sum;
        logic        start_matched;
        logic [7:0]  checksum_hold;
        logic        frame_finished;
        status_t     final_status;
    } frame_state_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  response_code;
        logic [15:0] payload_length;
    } result_t;

endpackage

### rtl/boot_packet_deframer.sv
// ----------------------------------------------------------------------------
// boot_packet_deframer: serial boot response deframer
// A result appears on the master side in the cycle after its word is
// accepted. Throughput: one word per cycle; the output register lets
// the next word in while a result waits, as long as m_tready is high.
// Reset (aresetn low, synchronous) clears the frame state and the output
// valid and loads the register defaults 0x81, 0x03 and 0x80.
// ----------------------------------------------------------------------------
module boot_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // buffer_end
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [10:8] status, [18:11] response_code,
    // [34:19] payload_length, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tuser    // is_status
);
    import bpd_pkg::*;

    cfg_t         cfg_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    logic         res_valid;
    result_t      res;
    logic         m_valid_reg;
    result_t      m_res_reg;
    logic         s_accept;
    logic         cfg_write;
    logic [1:0]   reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte <= START_BYTE_RESET;
            cfg_reg.end_byte   <= END_BYTE_RESET;
            cfg_reg.error_mask <= ERROR_MASK_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_START_BYTE: cfg_reg.start_byte <= pwdata[7:0];
                REG_END_BYTE:   cfg_reg.end_byte   <= pwdata[7:0];
                REG_ERROR_MASK: cfg_reg.error_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_index)
            REG_START_BYTE: prdata = {24'd0, cfg_reg.start_byte};
            REG_END_BYTE:   prdata = {24'd0, cfg_reg.end_byte};
            REG_ERROR_MASK: prdata = {24'd0, cfg_reg.error_mask};
            default:        prdata = 32'd0;
        endcase
    end

    bpd_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .rx_byte    (s_tdata),
        .buffer_end (s_tlast),
        .nxt        (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Accept a word whenever the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Advance the frame state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Hold a result until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.is_status;
    assign m_tdata  = {5'd0, m_res_reg.payload_length, m_res_reg.response_code,
                       m_res_reg.status, m_res_reg.payload_byte};

endmodule

### rtl/bpd_step.sv
// ----------------------------------------------------------------------------
// bpd_step: per-word frame parser
// Computes the next frame state and the result (payload word or buffer
// status) caused by one received word.
// ----------------------------------------------------------------------------
module bpd_step (
    input  bpd_pkg::cfg_t         cfg,
    input  bpd_pkg::frame_state_t cur,
    input  logic [7:0]            rx_byte,
    input  logic                  buffer_end,
    output bpd_pkg::frame_state_t nxt,
    output logic                  res_valid,
    output bpd_pkg::result_t      res
);
    import bpd_pkg::*;

    logic [15:0]  body_len;
    logic [16:0]  cks_pos;
    logic [7:0]   sum_plus;
    logic [7:0]   expect_cks;
    logic         emit;
    frame_state_t upd;
    status_t      end_status;

    assign body_len   = cur.frame_length - 16'd1;
    assign cks_pos    = {1'b0, body_len} + HEADER_BYTES;
    assign sum_plus   = cur.running_sum + rx_byte;
    assign expect_cks = 8'd0 - cur.running_sum;

    // Parse the word by its position in the frame
    always_comb begin
        upd  = cur;
        emit = 1'b0;
        if (!cur.frame_finished) begin
            if (cur.byte_position == 17'd0) begin
                upd.start_matched = (rx_byte == cfg.start_byte);
            end else if (cur.byte_position == 17'd1) begin
                upd.frame_length = {rx_byte, 8'h00};
                upd.running_sum  = sum_plus;
            end else if (cur.byte_position == 17'd2) begin
                upd.frame_length = {cur.frame_length[15:8], rx_byte};
                upd.running_sum  = sum_plus;
            end else if (cur.byte_position == 17'd3) begin
                upd.response_hold = rx_byte;
                upd.running_sum   = sum_plus;
            end else if (cur.start_matched && (cur.frame_length != 16'd0)) begin
                if (cur.byte_position < cks_pos) begin
                    upd.running_sum = sum_plus;
                    emit            = 1'b1;
                end else if (cur.byte_position == cks_pos) begin
                    upd.checksum_hold = rx_byte;
                end else if (cur.byte_position == cks_pos + 17'd1) begin
                    if ((cur.response_hold & cfg.error_mask) != 8'd0) begin
                        upd.final_status = ST_DEV_ERROR;
                    end else if (rx_byte != cfg.end_byte) begin
                        upd.final_status = ST_BAD_END;
                    end else if (cur.checksum_hold != expect_cks) begin
                        upd.final_status = ST_CHECKSUM;
                    end else begin
                        upd.final_status = ST_OK;
                    end
                    upd.frame_finished = 1'b1;
                end
            end
        end
        // Advance the saturating word counter
        if (cur.byte_position != '1) begin
            upd.byte_position = cur.byte_position + 17'd1;
        end
    end

    // Pick the buffer status in priority order
    always_comb begin
        if (upd.frame_finished) begin
            end_status = upd.final_status;
        end else if (upd.byte_position < MIN_FRAME_BYTES) begin
            end_status = ST_TRUNCATED;
        end else if (!upd.start_matched) begin
            end_status = ST_BAD_START;
        end else if (upd.frame_length == 16'd0) begin
            end_status = ST_ZERO_LEN;
        end else begin
            end_status = ST_TRUNCATED;
        end
    end

    // Build the result and clear the frame at the end of the buffer
    always_comb begin
        res.is_status      = buffer_end;
        res.payload_byte   = buffer_end ? 8'd0 : rx_byte;
        res.status         = buffer_end ? end_status : ST_OK;
        res.response_code  = upd.response_hold;
        res.payload_length = (upd.frame_length != 16'd0) ?
                             (upd.frame_length - 16'd1) : 16'd0;
        res_valid          = buffer_end || emit;
        nxt                = upd;
        if (buffer_end) begin
            nxt = '0;
        end
    end

endmodule

### test/boot_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// boot_packet_deframer_test: self-checking bench for the boot packet deframer
// Drives receive buffers word by word on the slave stream, computes the
// expected payload words and buffer status, and checks every master word
// against them. A short table covers reset defaults and all statuses but bad
// end and checksum. Random frames follow, under four register settings.
// ----------------------------------------------------------------------------
module boot_packet_deframer_test;
    import bpd_pkg::*;

    localparam int          CYCLE_LIMIT       = 5_000_000;
    localparam int          PHASE_WORDS       = 325;
    localparam logic [16:0] POS_SATURATED     = 17'h1FFFF;

    typedef struct packed {
        logic [7:0] rx;
        logic       last;
        logic       pin;    // status typed in below
        status_t    st;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // register mirror
    logic [7:0] cfg_start = START_BYTE_RESET;
    logic [7:0] cfg_end   = END_BYTE_RESET;
    logic [7:0] cfg_mask  = ERROR_MASK_RESET;

    // deframer state mirror
    logic [16:0] pos_cnt    = '0;
    logic [15:0] len_field  = '0;
    logic [7:0]  resp_byte  = '0;
    logic [7:0]  sum_acc    = '0;
    logic        start_ok   = 1'b0;
    logic [7:0]  cks_byte   = '0;
    logic        frame_done = 1'b0;
    status_t     done_status = ST_OK;

    result_t     deframed_q[$];

    logic [31:0] cycle_cnt    = '0;
    logic [1:0]  stall_mode   = '0;
    int          mismatch_cnt = 0;
    int          words_sent   = 0;
    int          burst_left   = 0;
    int          payload_seen = 0;
    int          status_seen[8];

    // reset defaults, statuses but bad end/checksum, a one-byte payload of 0xFF
    stim_row_t directed_rows[26] = '{
        '{8'hFF, 1'b1, 1'b1, ST_TRUNCATED},
        '{8'h81, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h10, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hEF, 1'b0, 1'b0, ST_OK},
        '{8'h03, 1'b1, 1'b1, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_BAD_START},
        '{8'h81, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h05, 1'b0, 1'b0, ST_OK},
        '{8'hAA, 1'b0, 1'b0, ST_OK}, '{8'hBB, 1'b1, 1'b1, ST_ZERO_LEN},
        '{8'h81, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h80, 1'b0, 1'b0, ST_OK},
        '{8'h5A, 1'b0, 1'b0, ST_OK}, '{8'h77, 1'b1, 1'b1, ST_DEV_ERROR}
    };

    boot_packet_deframer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .s_tlast  (s_tlast),   // buffer_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] payload, [10:8] status, [18:11] response,
                               // [34:19] payload length, [39:35] zero
        .m_tuser  (m_tuser)    // is_status
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("MISMATCH %s", msg);
        end
    endtask

    // Advance the mirror by one received byte and queue the result it causes
    task automatic deframe_byte(input logic [7:0] b, input logic last,
                                input logic pin, input status_t pin_st);
        int         dl;
        logic [7:0] sum_neg;
        logic       payload;
        result_t    r;
        payload = 1'b0;
        if (!frame_done) begin
            dl = int'(len_field) - 1;
            case (pos_cnt)
                17'd0: start_ok = (b == cfg_start);
                17'd1: begin
                    len_field = {b, 8'h00};
                    sum_acc   = sum_acc + b;
                end
                17'd2: begin
                    len_field[7:0] = b;
                    sum_acc        = sum_acc + b;
                end
                17'd3: begin
                    resp_byte = b;
                    sum_acc   = sum_acc + b;
                end
                default: begin
                    if (start_ok && len_field != 16'd0) begin
                        if (int'(pos_cnt) < int'(HEADER_BYTES) + dl) begin
                            sum_acc = sum_acc + b;
                            payload = 1'b1;
                        end else if (int'(pos_cnt) == int'(HEADER_BYTES) + dl) begin
                            cks_byte = b;
                        end else if (int'(pos_cnt) == int'(HEADER_BYTES) + dl + 1) begin
                            sum_neg = 8'h00 - sum_acc;
                            if ((resp_byte & cfg_mask) != 8'h00) begin
                                done_status = ST_DEV_ERROR;
                            end else if (b != cfg_end) begin
                                done_status = ST_BAD_END;
                            end else if (cks_byte != sum_neg) begin
                                done_status = ST_CHECKSUM;
                            end else begin
                                done_status = ST_OK;
                            end
                            frame_done = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (pos_cnt != POS_SATURATED) begin
            pos_cnt++;
        end

        r.response_code  = resp_byte;
        r.payload_length = (len_field != 16'd0) ? len_field - 16'd1 : 16'd0;
        if (last) begin
            r.is_status    = 1'b1;
            r.payload_byte = 8'h00;
            if (frame_done) begin
                r.status = done_status;
            end else if (pos_cnt < MIN_FRAME_BYTES) begin
                r.status = ST_TRUNCATED;
            end else if (!start_ok) begin
                r.status = ST_BAD_START;
            end else if (len_field == 16'd0) begin
                r.status = ST_ZERO_LEN;
            end else begin
                r.status = ST_TRUNCATED;
            end
            if (pin) begin
                r.status = pin_st;
            end
            deframed_q.push_back(r);
            // drop the frame state at every buffer end
            pos_cnt     = '0;
            len_field   = '0;
            resp_byte   = '0;
            sum_acc     = '0;
            start_ok    = 1'b0;
            cks_byte    = '0;
            frame_done  = 1'b0;
            done_status = ST_OK;
        end else if (payload) begin
            r.is_status    = 1'b0;
            r.payload_byte = b;
            r.status       = ST_OK;
            deframed_q.push_back(r);
        end
    endtask

    // Send one word in bursts with random gaps, then predict its result
    task automatic push_word(input logic [7:0] b, input logic last,
                             input logic pin, input status_t pin_st);
        int gaps;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gaps = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            repeat (gaps) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        deframe_byte(b, last, pin, pin_st);
    endtask

    // Build one random buffer: mostly frames, some broken, some noise
    task automatic send_buffer();
        logic [7:0]  fb[$];
        logic [15:0] lf;
        logic [7:0]  resp;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          kind;
        int          dlen;
        int          cut;
        kind = $urandom_range(0, 99);
        if (kind < 18) begin
            repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
        end else begin
            if ($urandom_range(0, 11) == 0) begin
                fb.push_back(cfg_start ^ 8'($urandom_range(1, 255)));
            end else begin
                fb.push_back(cfg_start);
            end
            dlen = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(0, 12);
            lf = 16'(dlen + 1);
            if (kind < 23) begin
                lf = 16'h0000;
            end else if (kind < 30) begin
                // length far beyond the buffer: payload then truncated
                lf = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'h8000 | 16'($urandom));
            end
            fb.push_back(lf[15:8]);
            fb.push_back(lf[7:0]);
            resp = 8'($urandom);
            if (cfg_mask != 8'h00) begin
                if ($urandom_range(0, 3) == 0) begin
                    while ((resp & cfg_mask) == 8'h00) resp = 8'($urandom);
                end else begin
                    resp = resp & ~cfg_mask;
                end
            end
            fb.push_back(resp);
            sum = lf[15:8] + lf[7:0] + resp;
            repeat (dlen) begin
                b   = 8'($urandom);
                sum = sum + b;
                fb.push_back(b);
            end
            b = 8'h00 - sum;
            if ($urandom_range(0, 6) == 0) begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            fb.push_back(b);
            if ($urandom_range(0, 6) == 0) begin
                fb.push_back(cfg_end ^ 8'($urandom_range(1, 255)));
            end else begin
                fb.push_back(cfg_end);
            end
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
            end
            // cut some buffers short anywhere in the frame
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, fb.size() - 1);
                while (fb.size() > cut) void'(fb.pop_back());
            end
        end
        foreach (fb[i]) begin
            push_word(fb[i], i == fb.size() - 1, 1'b0, ST_OK);
        end
    endtask

    // Wait for every expected word, then for the pipeline to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_BYTE: cfg_start = val;
            REG_END_BYTE:   cfg_end   = val;
            REG_ERROR_MASK: cfg_mask  = val;
            default: ;
        endcase
    endtask

    // Read one register back and compare it with the mirror
    task automatic check_reg(input logic [1:0] idx);
        logic [7:0] want;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_START_BYTE: want = cfg_start;
            REG_END_BYTE:   want = cfg_end;
            default:        want = cfg_mask;
        endcase
        if (prdata[7:0] !== want) begin
            flag_mismatch($sformatf("register %0d read %02h, expected %02h",
                                    idx, prdata[7:0], want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [7:0] eb,
                              input logic [7:0] em);
        apb_write(REG_START_BYTE, sb);
        apb_write(REG_END_BYTE, eb);
        apb_write(REG_ERROR_MASK, em);
        check_reg(REG_START_BYTE);
        check_reg(REG_END_BYTE);
        check_reg(REG_ERROR_MASK);
    endtask

    // Stall the receiver, check each accepted word, watch the cycle budget
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("boot_packet_deframer_test NOT OK");
            $finish;
        end else begin
            if (cycle_cnt[6:0] == 7'd0) begin
                stall_mode <= 2'($urandom_range(0, 3));
            end
            case (stall_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (cycle_cnt[1:0] == 2'd0);
                default: m_tready <= ~cycle_cnt[3];
            endcase
            if (aresetn && m_tvalid && m_tready) begin
                got.is_status      = m_tuser;
                got.payload_byte   = m_tdata[7:0];
                got.status         = status_t'(m_tdata[10:8]);
                got.response_code  = m_tdata[18:11];
                got.payload_length = m_tdata[34:19];
                if (deframed_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word tuser=%0b tdata=%010h",
                                            m_tuser, m_tdata));
                end else begin
                    want = deframed_q.pop_front();
                    if (want.is_status) begin
                        status_seen[want.status]++;
                    end else begin
                        payload_seen++;
                    end
                    if (got.is_status !== want.is_status
                        || got.payload_byte !== want.payload_byte
                        || got.status !== want.status
                        || got.response_code !== want.response_code
                        || got.payload_length !== want.payload_length
                        || m_tdata[39:35] !== 5'd0) begin
                        flag_mismatch($sformatf({
                            "exp sts=%0b pay=%02h st=%0d rsp=%02h len=%0d, ",
                            "got sts=%0b pay=%02h st=%0d rsp=%02h len=%0d pad=%02h"},
                            want.is_status, want.payload_byte, want.status,
                            want.response_code, want.payload_length,
                            got.is_status, got.payload_byte, got.status,
                            got.response_code, got.payload_length, m_tdata[39:35]));
                    end
                end
            end
        end
    end

    initial begin
        int start_words;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_reg(REG_START_BYTE);
        check_reg(REG_END_BYTE);
        check_reg(REG_ERROR_MASK);

        // walk the directed table at the reset defaults
        foreach (directed_rows[i]) begin
            push_word(directed_rows[i].rx, directed_rows[i].last,
                      directed_rows[i].pin, directed_rows[i].st);
        end

        // random buffers under four register settings
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: set_config(8'($urandom), 8'($urandom), 8'($urandom));
                1: set_config(8'h00, 8'hFF, 8'h00);
                2: set_config(8'hFF, 8'h00, 8'hFF);
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            start_words = words_sent;
            while (words_sent - start_words < PHASE_WORDS) send_buffer();
        end
        settle();

        $display("covered %0d words in %0d buffers over five register settings,",
                 words_sent, status_seen.sum());
        $display("%0d payload words", payload_seen);
        $display("status mix: ok %0d trunc %0d start %0d zero %0d dev %0d end %0d cks %0d",
                 status_seen[ST_OK], status_seen[ST_TRUNCATED], status_seen[ST_BAD_START],
                 status_seen[ST_ZERO_LEN], status_seen[ST_DEV_ERROR],
                 status_seen[ST_BAD_END], status_seen[ST_CHECKSUM]);
        if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
            $display("boot_packet_deframer_test OK");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatch_cnt,
                     deframed_q.size());
            $display("boot_packet_deframer_test NOT OK");
        end
        $finish;
    end

endmodule
